@@ sv/blz_pkg.sv @@
// Shared types and constants of the backward LZSS decoder.
package blz_pkg;

  // History window: output bytes kept by address modulo the depth.
  localparam int unsigned HIST_AW    = 13;
  localparam int unsigned HIST_DEPTH = 1 << HIST_AW;

  // Token decoding constants.
  localparam logic [4:0]  LEN_BIAS       = 5'd3;
  localparam logic [12:0] DIST_BIAS      = 13'd2;
  localparam logic [3:0]  FLAGS_PER_CTRL = 4'd8;

  // Block status as reported on every last result of an item.
  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    CS_IDLE,
    CS_COPY
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // an input item is transferred this cycle
    logic copy_adv;  // move the back-reference copy one byte on
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic copy_start;  // the offered item starts a back-reference copy
    logic copy_done;   // the copy byte leaving now is the last one
  } dp_stat_t;

endpackage

@@ sv/blz_if.sv @@
// Stream channel interfaces for encoded input and decoded results.
interface blz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface blz_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] write_position;
  logic        has_data;
  logic        run_end;
  logic [1:0]  status;

  modport source (output valid, output data_byte, output write_position, output has_data,
                  output run_end, output status, input ready);
  modport sink   (input valid, input data_byte, input write_position, input has_data,
                  input run_end, input status, output ready);
endinterface

@@ sv/backward_lzss_decompressor.sv @@
// Top level of the backward LZSS decoder.
// Writing output_size starts a block; encoded bytes then arrive in descending address
// order and decoded bytes leave in descending address order, each with its address.
// The low byte of a pair that copies N bytes (3 to 18) holds off input while the copy
// runs through the 8192-byte history memory, which serves one read and one write per
// cycle; result back-pressure stalls input and copy alike. The history needs no
// clearing after reset. After an error or the final byte the block answers every item
// with one status-only result until the next size write.
module backward_lzss_decompressor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  blz_in_if.sink           in_i,
  blz_out_if.source        out_o
);

  blz_pkg::ctrl_cmd_t ctrl_cmd;
  blz_pkg::dp_stat_t  dp_stat;

  blz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  blz_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_code_i      (in_i.code_byte),
    .in_final_i     (in_i.final_byte),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_data_o     (out_o.data_byte),
    .out_wpos_o     (out_o.write_position),
    .out_has_data_o (out_o.has_data),
    .out_run_end_o  (out_o.run_end),
    .out_status_o   (out_o.status)
  );

  // No input transfer while a copy is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.copy_adv |-> !(in_i.valid && in_i.ready))
    else $error("input transfer during back-reference copy");

  // Only data bytes precede the last result of an item, and they report running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.run_end) |->
      (out_o.has_data && out_o.status == blz_pkg::ST_RUN))
    else $error("non-final result without data or with a final status");

  // Status-only results carry a zero data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.has_data) |-> (out_o.data_byte == 8'd0))
    else $error("status-only result with nonzero data");

  // A copy step always hands a byte to the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.copy_adv |=> (out_o.valid && out_o.has_data))
    else $error("copy step produced no data result");

endmodule

@@ sv/blz_ctrl.sv @@
// Controller state machine: item acceptance and back-reference copy sequencing.
module blz_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blz_pkg::dp_stat_t   stat_i,
  output blz_pkg::ctrl_cmd_t  cmd_o
);

  blz_pkg::ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blz_pkg::CS_IDLE: begin
        if (in_valid_i && stat_i.out_free && stat_i.copy_start) begin
          state_d = blz_pkg::CS_COPY;
        end
      end
      blz_pkg::CS_COPY: begin
        if (stat_i.out_free && stat_i.copy_done) begin
          state_d = blz_pkg::CS_IDLE;
        end
      end
      default: state_d = blz_pkg::CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.copy_adv = 1'b0;
    case (state_q)
      blz_pkg::CS_IDLE: begin
        in_ready_o = stat_i.out_free;
        cmd_o.step = in_valid_i && stat_i.out_free;
      end
      blz_pkg::CS_COPY: begin
        cmd_o.copy_adv = stat_i.out_free;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blz_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/blz_dp.sv @@
// Datapath: token decoding, decoder state, history memory and result register.
module blz_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [7:0]         in_code_i,
  input  logic               in_final_i,
  input  blz_pkg::ctrl_cmd_t cmd_i,
  output blz_pkg::dp_stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_data_o,
  output logic [31:0]        out_wpos_o,
  output logic               out_has_data_o,
  output logic               out_run_end_o,
  output logic [1:0]         out_status_o
);

  localparam int unsigned AW = blz_pkg::HIST_AW;

  // Decoder state
  logic [31:0]      osize_q, osize_d;
  logic [31:0]      wp_q, wp_d;
  logic [7:0]       flag_bits_q, flag_bits_d;
  logic [3:0]       flags_left_q, flags_left_d;
  logic [7:0]       pair_high_q, pair_high_d;
  logic             pair_phase_q, pair_phase_d;
  blz_pkg::status_e halted_q, halted_d;

  // Copy sequencing
  logic [AW-1:0]    src_q, src_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             fin_q, fin_d;

  // History memory
  logic [7:0]       hist_mem [blz_pkg::HIST_DEPTH];
  logic [7:0]       rd_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [7:0]       ld_data;
  logic [31:0]      ld_wpos;
  logic             ld_has, ld_end;
  blz_pkg::status_e ld_status;
  logic [7:0]       data_q;
  logic [31:0]      wpos_q;
  logic             has_q, end_q;
  logic [1:0]       status_q;

  // Pair decoding
  logic [4:0]       pair_len;
  logic [12:0]      pair_dist;
  logic [32:0]      src_full;
  logic             pair_err;
  logic             is_pair;
  logic [31:0]      wp_m1;
  logic             out_free;

  assign wp_m1     = wp_q - 32'd1;
  assign pair_len  = {1'b0, pair_high_q[7:4]} + blz_pkg::LEN_BIAS;
  assign pair_dist = {1'b0, pair_high_q[3:0], in_code_i} + blz_pkg::DIST_BIAS;
  assign src_full  = {1'b0, wp_q} + {20'd0, pair_dist};
  assign pair_err  = (wp_q < {27'd0, pair_len}) || (src_full >= {1'b0, osize_q});
  assign is_pair   = (halted_q == blz_pkg::ST_RUN) && (flags_left_q != 4'd0)
                     && flag_bits_q[7] && pair_phase_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign stat_o.out_free   = out_free;
  assign stat_o.copy_start = is_pair && !pair_err;
  assign stat_o.copy_done  = (cnt_q == 5'd0);

  // Decode items, sequence copies and take configuration writes
  always_comb begin
    osize_d      = osize_q;
    wp_d         = wp_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    pair_high_d  = pair_high_q;
    pair_phase_d = pair_phase_q;
    halted_d     = halted_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    fin_d        = fin_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    out_load     = 1'b0;
    ld_data      = '0;
    ld_wpos      = wp_q;
    ld_has       = 1'b0;
    ld_end       = 1'b1;
    ld_status    = halted_q;

    if (cmd_i.step) begin
      out_load = 1'b1;
      if (halted_q != blz_pkg::ST_RUN) begin
        // hold everything, report the halted status
      end else if (flags_left_q == 4'd0) begin
        // control byte
        flag_bits_d  = in_code_i;
        flags_left_d = (wp_q == 32'd0) ? 4'd0 : blz_pkg::FLAGS_PER_CTRL;
        halted_d     = in_final_i ? blz_pkg::ST_DONE : blz_pkg::ST_RUN;
      end else if (flag_bits_q[7] && !pair_phase_q) begin
        // high byte of a pair
        pair_high_d  = in_code_i;
        pair_phase_d = 1'b1;
        halted_d     = in_final_i ? blz_pkg::ST_ERR : blz_pkg::ST_RUN;
      end else if (flag_bits_q[7]) begin
        // low byte of a pair: reject or start the copy with its first read
        pair_phase_d = 1'b0;
        if (pair_err) begin
          halted_d = blz_pkg::ST_ERR;
        end else begin
          out_load  = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = src_full[AW-1:0];
          src_d     = src_full[AW-1:0] - AW'(1);
          cnt_d     = pair_len - 5'd1;
          fin_d     = in_final_i;
        end
      end else if (wp_q == 32'd0) begin
        // literal with no room
        halted_d = blz_pkg::ST_ERR;
      end else begin
        // literal
        mem_we       = 1'b1;
        mem_waddr    = wp_m1[AW-1:0];
        mem_wdata    = in_code_i;
        wp_d         = wp_m1;
        ld_data      = in_code_i;
        ld_wpos      = wp_m1;
        ld_has       = 1'b1;
        flag_bits_d  = {flag_bits_q[6:0], 1'b0};
        flags_left_d = (wp_m1 == 32'd0) ? 4'd0 : flags_left_q - 4'd1;
        halted_d     = in_final_i ? blz_pkg::ST_DONE : blz_pkg::ST_RUN;
      end
      ld_status = halted_d;
    end

    if (cmd_i.copy_adv) begin
      // issue the next read while the previous byte is written and sent
      if (cnt_q != 5'd0) begin
        mem_re    = 1'b1;
        mem_raddr = src_q;
        src_d     = src_q - AW'(1);
        cnt_d     = cnt_q - 5'd1;
      end
      mem_we    = 1'b1;
      mem_waddr = wp_m1[AW-1:0];
      mem_wdata = rd_q;
      wp_d      = wp_m1;
      out_load  = 1'b1;
      ld_data   = rd_q;
      ld_wpos   = wp_m1;
      ld_has    = 1'b1;
      ld_end    = (cnt_q == 5'd0);
      ld_status = blz_pkg::ST_RUN;
      if (cnt_q == 5'd0) begin
        flag_bits_d  = {flag_bits_q[6:0], 1'b0};
        flags_left_d = (wp_m1 == 32'd0) ? 4'd0 : flags_left_q - 4'd1;
        halted_d     = fin_q ? blz_pkg::ST_DONE : blz_pkg::ST_RUN;
        ld_status    = halted_d;
      end
    end

    // a size write starts a new block
    if (cfg_we_i) begin
      osize_d      = cfg_wdata_i;
      wp_d         = cfg_wdata_i;
      flag_bits_d  = '0;
      flags_left_d = '0;
      pair_high_d  = '0;
      pair_phase_d = 1'b0;
      halted_d     = blz_pkg::ST_RUN;
    end
  end

  // Advance the result valid flag
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osize_q      <= '0;
      wp_q         <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      pair_high_q  <= '0;
      pair_phase_q <= 1'b0;
      halted_q     <= blz_pkg::ST_RUN;
      cnt_q        <= '0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      osize_q      <= osize_d;
      wp_q         <= wp_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      pair_high_q  <= pair_high_d;
      pair_phase_q <= pair_phase_d;
      halted_q     <= halted_d;
      cnt_q        <= cnt_d;
      fin_q        <= fin_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    if (out_load) begin
      data_q   <= ld_data;
      wpos_q   <= ld_wpos;
      has_q    <= ld_has;
      end_q    <= ld_end;
      status_q <= ld_status;
    end
  end

  // History memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= hist_mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = data_q;
  assign out_wpos_o     = wpos_q;
  assign out_has_data_o = has_q;
  assign out_run_end_o  = end_q;
  assign out_status_o   = status_q;

endmodule
